// ===== rtl/hd_pkg.sv =====
// Shared constants, types and state encoding for the Hassanat distance core.
package hd_pkg;

	// Fixed-point format of elements, terms and the running sum
	localparam int FRAC_BITS = 16;
	localparam int ELEM_W    = 32;
	localparam int SUM_W     = 32;

	// Divider widths: denominator can reach 2^32 - 1 + 2^F, so one extra bit
	localparam int DEN_W = ELEM_W + 1;
	localparam int REM_W = DEN_W + 1;
	localparam int CNT_W = $clog2(FRAC_BITS);

	// Fixed-point one, at denominator width
	localparam logic [DEN_W-1:0] FX_ONE = DEN_W'(1) << FRAC_BITS;

	// Sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_HOLD
	} hd_state_t;

	// Divider start request
	typedef struct packed {
		logic              start;
		logic [ELEM_W-1:0] dividend;
		logic [DEN_W-1:0]  divisor;
	} hd_div_req_t;

	// Divider status and result
	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic [FRAC_BITS-1:0] quot;
	} hd_div_rsp_t;

endpackage

// ===== rtl/hd_if.sv =====
// Valid/ready channel interfaces for element pairs and distance results.
interface hd_in_if
	import hd_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic signed [ELEM_W-1:0] elem_a;
	logic signed [ELEM_W-1:0] elem_b;
	logic                     last_pair;

	modport source (output valid, output elem_a, output elem_b, output last_pair, input ready);
	modport sink   (input valid, input elem_a, input elem_b, input last_pair, output ready);
endinterface

interface hd_out_if
	import hd_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [SUM_W-1:0] distance;

	modport source (output valid, output distance, input ready);
	modport sink   (input valid, input distance, output ready);
endinterface

// ===== rtl/hd_div.sv =====
// Iterative restoring divider: one quotient bit per cycle, FRAC_BITS-bit fraction.
module hd_div
	import hd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  hd_div_req_t req,
	output hd_div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DEN_W-1:0]     den_q;
	logic [FRAC_BITS-1:0] quot_q;

	logic [REM_W-1:0] shifted;
	logic [REM_W-1:0] den_ext;
	logic [REM_W-1:0] trial;
	logic             fits;

	// Trial subtract of the shifted partial remainder
	always_comb begin
		shifted = {rem_q, 1'b0};
		den_ext = {1'b0, den_q};
		trial   = shifted - den_ext;
		fits    = shifted >= den_ext;
	end

	// Control: busy for FRAC_BITS steps, done pulses once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(FRAC_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Datapath: remainder, divisor and quotient shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= {1'b0, req.dividend};
			den_q <= req.divisor;
		end else if (busy_q) begin
			rem_q  <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
			quot_q <= {quot_q[FRAC_BITS-2:0], fits};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

	// Partial remainder stays below the divisor, so each step yields one bit
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q < den_q)
		else $error("divider remainder not below divisor");

	// Done follows the final step
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q)
		else $error("divider done without preceding step");

endmodule

// ===== rtl/hassanat_distance_core.sv =====
// Hassanat distance core: element pair preparation, sequencer, accumulator, output register.
// The core takes no new pair until the restoring divider, which produces one quotient
// bit per cycle, has finished the current one; pair_in is not ready meanwhile.
// A waiting result does not block the next pair; a later last pair holds until it drains.
// Reset (arst_n low): running sum cleared, sequencer idle, output register empty.
module hassanat_distance_core
	import hd_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	hd_in_if.sink   pair_in,
	hd_out_if.source dist_out
);

	hd_state_t   state_q, state_d;
	hd_div_req_t div_req;
	hd_div_rsp_t div_rsp;

	logic             last_q;
	logic [SUM_W-1:0] sum_q, sum_d;
	logic             out_valid_q, out_valid_d;
	logic [SUM_W-1:0] out_data_q, out_data_d;
	logic             last_d;

	logic                     accept;
	logic signed [ELEM_W-1:0] lo;
	logic signed [ELEM_W-1:0] hi;
	logic [ELEM_W-1:0]        diff;
	logic [SUM_W:0]           sum_ext;
	logic [SUM_W-1:0]         sum_sat;
	logic                     slot_free;

	assign accept    = pair_in.valid && pair_in.ready;
	assign slot_free = !out_valid_q || dist_out.ready;

	// Operand preparation: order the pair, form numerator and denominator
	always_comb begin
		if (pair_in.elem_a < pair_in.elem_b) begin
			lo = pair_in.elem_a;
			hi = pair_in.elem_b;
		end else begin
			lo = pair_in.elem_b;
			hi = pair_in.elem_a;
		end
		diff             = $unsigned(hi) - $unsigned(lo);
		div_req.start    = accept;
		div_req.dividend = diff;
		div_req.divisor  = lo[ELEM_W-1] ? FX_ONE + {1'b0, diff}
		                                 : FX_ONE + {1'b0, $unsigned(hi)};
	end

	hd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Saturating add of the new term
	always_comb begin
		sum_ext = {1'b0, sum_q} + {{(SUM_W + 1 - FRAC_BITS){1'b0}}, div_rsp.quot};
		sum_sat = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
	end

	// Sequencer next state and register updates
	always_comb begin
		state_d     = state_q;
		sum_d       = sum_q;
		last_d      = last_q;
		out_valid_d = out_valid_q && !dist_out.ready;
		out_data_d  = out_data_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					last_d  = pair_in.last_pair;
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (div_rsp.done) begin
					if (!last_q) begin
						sum_d   = sum_sat;
						state_d = S_IDLE;
					end else if (slot_free) begin
						out_data_d  = sum_sat;
						out_valid_d = 1'b1;
						sum_d       = '0;
						state_d     = S_IDLE;
					end else begin
						sum_d   = sum_sat;
						state_d = S_HOLD;
					end
				end
			end
			S_HOLD: begin
				if (slot_free) begin
					out_data_d  = sum_q;
					out_valid_d = 1'b1;
					sum_d       = '0;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			sum_q       <= sum_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		last_q     <= last_d;
		out_data_q <= out_data_d;
	end

	assign pair_in.ready     = (state_q == S_IDLE);
	assign dist_out.valid    = out_valid_q;
	assign dist_out.distance = out_data_q;

	// A new pair never arrives while the divider is still iterating
	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider restarted while busy");

	// Divider completion is only seen while the sequencer waits on it
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_DIV)
		else $error("divider done outside divide state");

	// Accepted pair starts the divider
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> div_rsp.busy && state_q == S_DIV)
		else $error("accepted pair did not start divider");

	// A result is loaded only from the divide or hold states
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DIV || $past(state_q) == S_HOLD)
		else $error("result loaded from unexpected state");

endmodule
